>>> hdl/gfba_pkg.sv
// Shared constants, codes and types for the grouped free block allocator.
package gfba_pkg;

  localparam int FREE_SLOTS = 32;
  localparam int SLOT_AW    = $clog2(FREE_SLOTS);
  localparam int CNT_W      = 6;
  localparam int BLK_W      = 24;
  localparam int CMD_W      = 2;
  localparam int KIND_W     = 3;

  localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(FREE_SLOTS);
  localparam logic [BLK_W-1:0] SLOTS_BLK = BLK_W'(FREE_SLOTS);
  localparam logic [SLOT_AW-1:0] LAST_SLOT = SLOT_AW'(FREE_SLOTS - 1);

  // Request codes
  localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FILL  = 2'd2;

  // Result codes
  localparam logic [KIND_W-1:0] KIND_ALLOCATED = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FREED     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_SPILL     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_FILL_REQ  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NO_SPACE  = 3'd4;
  localparam logic [KIND_W-1:0] KIND_BUSY      = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ALLOC_RD,
    ST_SPILL
  } state_t;

endpackage

>>> hdl/gfba_stack_ram.sv
// Single write port, single read port RAM with registered read data.
module gfba_stack_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/grouped_free_block_allocator_unit.sv
// Grouped free block allocator: free block stack in RAM with spill and fill control.
//
// Send a request by raising start while busy is low; the item is taken at that
// clock edge. Every result appears on the out_ ports for exactly one cycle with
// out_valid high and cannot be held off, so capture it when it shows. Free,
// fill-word and rejected requests give their result in the cycle after they are
// taken, as does an allocate on an empty stack (no space). Any other
// allocate keeps busy high for one cycle because the top entry
// comes out of the stack RAM in the cycle after its address is issued. A free on
// a full stack spills 1 + FREE_SLOTS words, one a cycle, as the RAM is swept
// one entry per cycle; busy stays high for the sweep. After a fill request,
// feed 1 + FREE_SLOTS fill words (cmd 2), one per accepted item; only the last
// one gives a result. Allocate or free during a fill is answered with busy
// rejected. The stack RAM holds no reset value and needs no clearing pass:
// entries are read only after they have been written.
module grouped_free_block_allocator_unit
  import gfba_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [CMD_W-1:0]  in_cmd,
  input  logic [BLK_W-1:0]  in_block_number,
  input  logic [BLK_W-1:0]  in_fill_word,
  output logic              out_valid,
  output logic [KIND_W-1:0] out_kind,
  output logic [BLK_W-1:0]  out_value,
  output logic [CNT_W-1:0]  out_word_index,
  output logic              out_last
);

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               filling_r, filling_nxt;
  logic [CNT_W-1:0]   fill_pos_r, fill_pos_nxt;
  logic               empty_flag_r, empty_flag_nxt;
  logic [BLK_W-1:0]   pending_r, pending_nxt;
  logic               link_r, link_nxt;         // allocate takes the link entry
  logic [BLK_W-1:0]   spill_blk_r, spill_blk_nxt;
  logic [SLOT_AW-1:0] spill_idx_r, spill_idx_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]  out_kind_r, out_kind_nxt;
  logic [BLK_W-1:0]   out_value_r, out_value_nxt;
  logic [CNT_W-1:0]   out_word_index_r, out_word_index_nxt;
  logic               out_last_r, out_last_nxt;

  logic               accept;
  logic               ram_we;
  logic [SLOT_AW-1:0] ram_waddr;
  logic [BLK_W-1:0]   ram_wdata;
  logic [SLOT_AW-1:0] ram_raddr;
  logic [BLK_W-1:0]   ram_rdata;

  assign busy   = (state_r != ST_IDLE);
  assign accept = start && !busy;

  gfba_stack_ram #(
    .WIDTH (BLK_W),
    .DEPTH (FREE_SLOTS),
    .AW    (SLOT_AW)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && !filling_r) begin
          if (in_cmd == CMD_ALLOC && count_r != '0) begin
            state_nxt = ST_ALLOC_RD;
          end else if (in_cmd == CMD_FREE && count_r >= SLOTS_CNT) begin
            state_nxt = ST_SPILL;
          end
        end
      end
      ST_ALLOC_RD: begin
        state_nxt = ST_IDLE;
      end
      ST_SPILL: begin
        if (spill_idx_r == LAST_SLOT) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Datapath, RAM access and result generation
  always_comb begin
    count_nxt          = count_r;
    filling_nxt        = filling_r;
    fill_pos_nxt       = fill_pos_r;
    empty_flag_nxt     = empty_flag_r;
    pending_nxt        = pending_r;
    link_nxt           = link_r;
    spill_blk_nxt      = spill_blk_r;
    spill_idx_nxt      = spill_idx_r;
    out_valid_nxt      = 1'b0;
    out_kind_nxt       = out_kind_r;
    out_value_nxt      = out_value_r;
    out_word_index_nxt = '0;
    out_last_nxt       = 1'b1;
    ram_we             = 1'b0;
    ram_waddr          = '0;
    ram_wdata          = in_block_number;
    ram_raddr          = '0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_FILL) begin
            if (filling_r) begin
              if (fill_pos_r == '0) begin
                // Word 0 carries the count of the link block
                if (in_fill_word == '0) begin
                  empty_flag_nxt = 1'b1;
                end else begin
                  empty_flag_nxt = 1'b0;
                  count_nxt = (in_fill_word > SLOTS_BLK) ? SLOTS_CNT
                                                         : in_fill_word[CNT_W-1:0];
                end
              end else if (!empty_flag_r && fill_pos_r <= SLOTS_CNT) begin
                ram_we    = 1'b1;
                ram_waddr = SLOT_AW'(fill_pos_r - 1'b1);
                ram_wdata = in_fill_word;
              end
              if (fill_pos_r >= SLOTS_CNT) begin
                filling_nxt   = 1'b0;
                fill_pos_nxt  = '0;
                out_valid_nxt = 1'b1;
                if (empty_flag_r) begin
                  // Empty link block: keep the link as the lone entry
                  empty_flag_nxt = 1'b0;
                  count_nxt      = CNT_W'(1);
                  out_kind_nxt   = KIND_NO_SPACE;
                  out_value_nxt  = '0;
                end else begin
                  out_kind_nxt  = KIND_ALLOCATED;
                  out_value_nxt = pending_r;
                end
              end else begin
                fill_pos_nxt = fill_pos_r + 1'b1;
              end
            end
          end else if (in_cmd == CMD_ALLOC || in_cmd == CMD_FREE) begin
            if (filling_r) begin
              out_valid_nxt = 1'b1;
              out_kind_nxt  = KIND_BUSY;
              out_value_nxt = '0;
            end else if (in_cmd == CMD_ALLOC) begin
              if (count_r == '0) begin
                out_valid_nxt = 1'b1;
                out_kind_nxt  = KIND_NO_SPACE;
                out_value_nxt = '0;
              end else begin
                // Fetch the top entry; the last one is the link block
                ram_raddr = SLOT_AW'(count_r - 1'b1);
                link_nxt  = (count_r == CNT_W'(1));
                if (count_r != CNT_W'(1)) begin
                  count_nxt = count_r - 1'b1;
                end
              end
            end else begin
              if (count_r >= SLOTS_CNT) begin
                // Full stack: emit the count, then sweep the entries
                out_valid_nxt = 1'b1;
                out_kind_nxt  = KIND_SPILL;
                out_value_nxt = BLK_W'(count_r);
                out_last_nxt  = 1'b0;
                ram_raddr     = '0;
                spill_blk_nxt = in_block_number;
                spill_idx_nxt = '0;
              end else begin
                ram_we        = 1'b1;
                ram_waddr     = count_r[SLOT_AW-1:0];
                ram_wdata     = in_block_number;
                count_nxt     = count_r + 1'b1;
                out_valid_nxt = 1'b1;
                out_kind_nxt  = KIND_FREED;
                out_value_nxt = in_block_number;
              end
            end
          end
        end
      end

      ST_ALLOC_RD: begin
        out_valid_nxt = 1'b1;
        out_value_nxt = ram_rdata;
        if (link_r) begin
          out_kind_nxt   = KIND_FILL_REQ;
          pending_nxt    = ram_rdata;
          filling_nxt    = 1'b1;
          fill_pos_nxt   = '0;
          empty_flag_nxt = 1'b0;
        end else begin
          out_kind_nxt = KIND_ALLOCATED;
        end
      end

      ST_SPILL: begin
        out_valid_nxt      = 1'b1;
        out_kind_nxt       = KIND_SPILL;
        out_value_nxt      = ram_rdata;
        out_word_index_nxt = CNT_W'(spill_idx_r) + 1'b1;
        out_last_nxt       = (spill_idx_r == LAST_SLOT);
        ram_raddr          = spill_idx_r + 1'b1;
        spill_idx_nxt      = spill_idx_r + 1'b1;
        if (spill_idx_r == LAST_SLOT) begin
          // Entry 0 was read first, so overwrite it with the new link now
          ram_we    = 1'b1;
          ram_waddr = '0;
          ram_wdata = spill_blk_r;
          count_nxt = CNT_W'(1);
        end
      end

      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      filling_r    <= 1'b0;
      fill_pos_r   <= '0;
      empty_flag_r <= 1'b0;
      pending_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      filling_r    <= filling_nxt;
      fill_pos_r   <= fill_pos_nxt;
      empty_flag_r <= empty_flag_nxt;
      pending_r    <= pending_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    link_r           <= link_nxt;
    spill_blk_r      <= spill_blk_nxt;
    spill_idx_r      <= spill_idx_nxt;
    out_kind_r       <= out_kind_nxt;
    out_value_r      <= out_value_nxt;
    out_word_index_r <= out_word_index_nxt;
    out_last_r       <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_value      = out_value_r;
  assign out_word_index = out_word_index_r;
  assign out_last       = out_last_r;

  // A spill stream runs without gaps until its last word
  a_spill_continuous: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_SPILL && !out_last |=> out_valid && out_kind == KIND_SPILL)
    else $error("spill stream broken");

  // The sweep only runs on a full stack
  a_spill_full: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SPILL |-> count_r == SLOTS_CNT)
    else $error("spill without full stack");

  // The count never exceeds the stack size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= SLOTS_CNT)
    else $error("free count overflow");

  // A fill request always opens a fill
  a_fill_req_opens: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_FILL_REQ |-> filling_r && fill_pos_r == '0)
    else $error("fill request without fill");

  // The fill position stays inside the link block
  a_fill_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_pos_r <= SLOTS_CNT)
    else $error("fill position out of range");

endmodule

>>> tb/sv/grouped_free_block_allocator_unit_test.sv
// Self-checking testbench for the grouped free block allocator unit.
module grouped_free_block_allocator_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import gfba_pkg::*;

  // cmd 3 has no meaning in the block; it must be dropped without a result
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  // Longest legal quiet stretch is a random sender gap plus an allocate;
  // allow many times that before calling the run hung.
  localparam int STALL_LIMIT = 400;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BLK_W-1:0]  value;
    logic [CNT_W-1:0]  word_index;
    logic              is_last;
  } alloc_result_t;

  // Shadow of the free list: predicts the result words of every accepted item
  // and checks what the block emits against them in order.
  class free_list_checker;
    logic [BLK_W-1:0] slots [FREE_SLOTS];
    int unsigned      count;
    bit               filling;
    int unsigned      fill_pos;
    logic [BLK_W-1:0] link_block;
    bit               link_empty;
    alloc_result_t    due_results[$];
    int               mismatches;

    function new();
      foreach (slots[i]) slots[i] = '0;
      count = 0;
      filling = 0;
      fill_pos = 0;
      link_block = '0;
      link_empty = 0;
      mismatches = 0;
    endfunction

    function void push_due(logic [KIND_W-1:0] kind, logic [BLK_W-1:0] value,
                           logic [CNT_W-1:0] word_index, logic is_last);
      alloc_result_t r;
      r.kind = kind;
      r.value = value;
      r.word_index = word_index;
      r.is_last = is_last;
      due_results.push_back(r);
    endfunction

    // Returns 1 when the block acts on the item, 0 when it drops it.
    function bit note_request(logic [CMD_W-1:0] cmd, logic [BLK_W-1:0] blk,
                              logic [BLK_W-1:0] word);
      if (cmd == CMD_FILL) begin
        if (!filling) return 0;
        if (fill_pos == 0) begin
          if (word == '0) begin
            link_empty = 1;
          end else begin
            link_empty = 0;
            count = (word > SLOTS_BLK) ? FREE_SLOTS : int'(word);
          end
        end else if (!link_empty && fill_pos <= FREE_SLOTS) begin
          slots[fill_pos - 1] = word;
        end
        if (fill_pos >= FREE_SLOTS) begin
          filling = 0;
          fill_pos = 0;
          if (link_empty) begin
            link_empty = 0;
            count = 1;
            push_due(KIND_NO_SPACE, '0, '0, 1'b1);
          end else begin
            push_due(KIND_ALLOCATED, link_block, '0, 1'b1);
          end
        end else begin
          fill_pos++;
        end
        return 1;
      end
      if (cmd != CMD_ALLOC && cmd != CMD_FREE) return 0;
      if (filling) begin
        push_due(KIND_BUSY, '0, '0, 1'b1);
        return 1;
      end
      if (cmd == CMD_ALLOC) begin
        if (count == 0) begin
          push_due(KIND_NO_SPACE, '0, '0, 1'b1);
        end else if (count == 1) begin
          link_block = slots[0];
          filling = 1;
          fill_pos = 0;
          link_empty = 0;
          push_due(KIND_FILL_REQ, link_block, '0, 1'b1);
        end else begin
          count--;
          push_due(KIND_ALLOCATED, slots[count], '0, 1'b1);
        end
        return 1;
      end
      if (count >= FREE_SLOTS) begin
        // Full stack: the count and every entry go out into the freed block
        push_due(KIND_SPILL, BLK_W'(count), '0, 1'b0);
        for (int i = 0; i < FREE_SLOTS; i++)
          push_due(KIND_SPILL, slots[i], CNT_W'(i + 1), (i + 1 == FREE_SLOTS));
        count = 1;
        slots[0] = blk;
      end else begin
        slots[count] = blk;
        count++;
        push_due(KIND_FREED, blk, '0, 1'b1);
      end
      return 1;
    endfunction

    function void check_result(logic [KIND_W-1:0] kind, logic [BLK_W-1:0] value,
                               logic [CNT_W-1:0] word_index, logic is_last);
      alloc_result_t want;
      if (due_results.size() == 0) begin
        $error("unexpected result: kind %0d value %0h word_index %0d last %0b",
               kind, value, word_index, is_last);
        mismatches++;
        return;
      end
      want = due_results.pop_front();
      if (kind !== want.kind) begin
        $error("kind: expected %0d, actual %0d", want.kind, kind);
        mismatches++;
      end
      if (value !== want.value) begin
        $error("value: expected %0h, actual %0h", want.value, value);
        mismatches++;
      end
      if (word_index !== want.word_index) begin
        $error("word_index: expected %0d, actual %0d", want.word_index, word_index);
        mismatches++;
      end
      if (is_last !== want.is_last) begin
        $error("last: expected %0b, actual %0b", want.is_last, is_last);
        mismatches++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [CMD_W-1:0]  in_cmd = CMD_ALLOC;
  logic [BLK_W-1:0]  in_block_number = '0;
  logic [BLK_W-1:0]  in_fill_word = '0;
  logic              out_valid;
  logic [KIND_W-1:0] out_kind;
  logic [BLK_W-1:0]  out_value;
  logic [CNT_W-1:0]  out_word_index;
  logic              out_last;

  free_list_checker sb;
  int taken_items = 0;
  int spills = 0;
  int fills = 0;
  int idle_cycles = 0;
  bit steady = 0;

  grouped_free_block_allocator_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_block_number (in_block_number),
    .in_fill_word    (in_fill_word),
    .out_valid       (out_valid),
    .out_kind        (out_kind),
    .out_value       (out_value),
    .out_word_index  (out_word_index),
    .out_last        (out_last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Results cannot be stalled: take every strobe at the edge that ends it.
  // Anything other than a clean low strobe after reset is checked.
  always @(posedge clk) begin
    if (rst_n && out_valid !== 1'b0)
      sb.check_result(out_kind, out_value, out_word_index, out_last);
  end

  // Watchdog: count cycles in which neither side moves anything.
  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_valid === 1'b1)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Field value with the extremes drawn often.
  function automatic logic [BLK_W-1:0] any_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return BLK_W'($urandom());
    endcase
  endfunction

  // Count word of a link block: empty, one, exactly full, oversized, or typical.
  function automatic logic [BLK_W-1:0] any_link_count();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return BLK_W'(1);
      2: return SLOTS_BLK;
      3: return BLK_W'($urandom_range(FREE_SLOTS + 1, 63));
      4: return '1;
      default: return BLK_W'($urandom_range(2, FREE_SLOTS - 1));
    endcase
  endfunction

  // Present one item and hold it until the block takes it. Change inputs only
  // at falling edges; a back-to-back item keeps start high with no dip.
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [BLK_W-1:0] blk,
                              input logic [BLK_W-1:0] word);
    int gap;
    // Switch now and then into a stretch with no sender gaps at all
    if ($urandom_range(0, 23) == 0) steady = !steady;
    gap = steady ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    in_cmd <= cmd;
    in_block_number <= blk;
    in_fill_word <= word;
    do @(posedge clk); while (busy !== 1'b0);
    if (sb.note_request(cmd, blk, word)) taken_items++;
  endtask

  task automatic free_block(input logic [BLK_W-1:0] blk);
    send_request(CMD_FREE, blk, any_word());
  endtask

  task automatic alloc_block();
    send_request(CMD_ALLOC, any_word(), any_word());
  endtask

  // Feed a whole link block: count word, then one word per slot. Mix in
  // requests that must be rejected and unused commands that must be dropped.
  task automatic fill_stream(input logic [BLK_W-1:0] link_count);
    for (int pos = 0; pos <= FREE_SLOTS; pos++) begin
      if ($urandom_range(0, 9) == 0)
        send_request($urandom_range(0, 1) ? CMD_ALLOC : CMD_FREE, any_word(), any_word());
      else if ($urandom_range(0, 19) == 0)
        send_request(CMD_UNUSED, any_word(), any_word());
      send_request(CMD_FILL, any_word(), (pos == 0) ? link_count : any_word());
    end
    fills++;
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty stack, dropped items, field extremes, link request,
    // rejects during the fill, and a link block whose count is zero.
    alloc_block();
    send_request(CMD_FILL, '1, '1);
    send_request(CMD_UNUSED, '1, '1);
    free_block('0);
    free_block('1);
    alloc_block();
    alloc_block();
    send_request(CMD_ALLOC, '1, '0);
    send_request(CMD_FREE, '1, '1);
    fill_stream('0);

    // Random: mostly well-formed episodes that fill the stack to a spill or
    // drain it into a link fill, with short mixed runs and noise between.
    while (taken_items < 180 || spills < 2 || fills < 3) begin
      if (sb.filling) fill_stream(any_link_count());
      case ($urandom_range(0, 8))
        0, 1, 2, 3: begin
          repeat ($urandom_range(1, 12)) begin
            if ($urandom_range(0, 9) < 6) free_block(any_word());
            else alloc_block();
            if (sb.filling) fill_stream(any_link_count());
          end
        end
        4, 5: begin
          while (sb.count < FREE_SLOTS) free_block(any_word());
          free_block(any_word());
          spills++;
        end
        6, 7: begin
          while (sb.count > 1) alloc_block();
          if (sb.count == 0) free_block(any_word());
          alloc_block();
          fill_stream(any_link_count());
        end
        default: begin
          send_request($urandom_range(0, 1) ? CMD_UNUSED : CMD_FILL, any_word(), any_word());
        end
      endcase
    end

    @(negedge clk);
    start <= 1'b0;
    // Let the last results come out, then watch a while for stray strobes
    while (sb.due_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
